### hw/rtl/blm_pkg.sv
// blm_pkg: shared widths, reset values, codes and item types of the battery level monitor
// no dependencies; imported by every module of the block
package blm_pkg;

  // field widths
  localparam int LEVEL_W  = 14;
  localparam int MV_W     = 13;
  localparam int MARGIN_W = 10;
  localparam int LED_W    = 2;

  // history default depth
  localparam int HISTORY_DEPTH_DEF = 15;

  // level code meaning "nothing shown yet"
  localparam logic [LEVEL_W-1:0] UNSET_LEVEL = LEVEL_W'(10001);

  // register reset values
  localparam logic [MV_W-1:0]     PRESENT_MV_RST  = MV_W'(1500);
  localparam logic [MV_W-1:0]     EXTERNAL_MV_RST = MV_W'(4300);
  localparam logic [LEVEL_W-1:0]  LOW_ENTER_RST   = LEVEL_W'(1000);
  localparam logic [LEVEL_W-1:0]  LOW_EXIT_RST    = LEVEL_W'(1500);
  localparam logic [MARGIN_W-1:0] FALL_MARGIN_RST = MARGIN_W'(100);

  // configuration port
  localparam int NUM_REGS = 5;
  localparam int PADDR_W  = $clog2(NUM_REGS) + 2;
  localparam int PDATA_W  = 32;

  typedef enum logic [PADDR_W-3:0] {
    REG_PRESENT_MV  = 3'd0,
    REG_EXTERNAL_MV = 3'd1,
    REG_LOW_ENTER   = 3'd2,
    REG_LOW_EXIT    = 3'd3,
    REG_FALL_MARGIN = 3'd4
  } blm_reg_t;

  // led pattern codes
  localparam logic [LED_W-1:0] LED_PULSE  = 2'd0;
  localparam logic [LED_W-1:0] LED_SOLID  = 2'd1;
  localparam logic [LED_W-1:0] LED_LOW    = 2'd2;
  localparam logic [LED_W-1:0] LED_ACTIVE = 2'd3;

  // one battery sample
  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [MV_W-1:0]    millivolts;
    logic               docked;
    logic               charging;
    logic               charged;
  } blm_sample_t;

  // one result item
  typedef struct packed {
    logic               battery_present;
    logic               external_power;
    logic               power_off_request;
    logic               low_battery;
    logic [LEVEL_W-1:0] reported_level;
    logic               power_source;
    logic [LED_W-1:0]   led_pattern;
    logic               first_sample;
  } blm_result_t;

  // average handed from the sequencer to the result logic
  typedef struct packed {
    logic               valid;
    logic [LEVEL_W-1:0] value;
  } blm_avg_t;

endpackage

### hw/rtl/battery_level_monitor.sv
// battery_level_monitor: top level with configuration registers, flags and result register
// depends on blm_pkg and blm_seq
//
// Takes one battery sample at a time and returns one result item per sample. After a
// sample is accepted, the history memory is read one entry per cycle through its single
// read port, then come a drain state, a state that writes the sample back and starts the
// divide, a wait for the quotient and the hand-off to the output register once the output
// side is free; only then can the next sample be taken. The sum is divided by
// HISTORY_DEPTH + 1 with a shift when that is a power of two, else with one reciprocal
// multiply. A finished result waits in the output register while the next sample is
// processed. Configuration registers sit at byte addresses 0, 4, 8, 12 and 16 and are
// to be written only while no sample is in work.
module battery_level_monitor import blm_pkg::*; #(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               sample_valid,
  output logic               sample_stall,
  input  blm_sample_t        sample,
  output logic               result_valid,
  input  logic               result_stall,
  output blm_result_t        result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  logic [MV_W-1:0]     present_mv;
  logic [MV_W-1:0]     external_mv;
  logic [LEVEL_W-1:0]  low_enter_level;
  logic [LEVEL_W-1:0]  low_exit_level;
  logic [MARGIN_W-1:0] fall_margin;

  logic                busy;
  blm_sample_t         cur;
  logic [LEVEL_W:0]    shown_level;
  logic                low_flag;
  logic                started;
  blm_avg_t            avg;
  logic                accept;
  logic                take;

  logic                present;
  logic                external;
  logic                low_next;
  logic [LEVEL_W:0]    avg_margin;
  logic [LEVEL_W:0]    shown_next;
  logic [LED_W-1:0]    led;
  logic [PADDR_W-3:0]  reg_idx;

  assign accept       = sample_valid && !sample_stall;
  assign sample_stall = busy;
  assign take         = avg.valid && (!result_valid || !result_stall);
  assign pready       = 1'b1;
  assign reg_idx      = paddr[PADDR_W-1:2];

  blm_seq #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (accept),
    .level   (sample.level),
    .take    (take),
    .avg_out (avg)
  );

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      present_mv      <= PRESENT_MV_RST;
      external_mv     <= EXTERNAL_MV_RST;
      low_enter_level <= LOW_ENTER_RST;
      low_exit_level  <= LOW_EXIT_RST;
      fall_margin     <= FALL_MARGIN_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        REG_PRESENT_MV:  present_mv      <= pwdata[MV_W-1:0];
        REG_EXTERNAL_MV: external_mv     <= pwdata[MV_W-1:0];
        REG_LOW_ENTER:   low_enter_level <= pwdata[LEVEL_W-1:0];
        REG_LOW_EXIT:    low_exit_level  <= pwdata[LEVEL_W-1:0];
        REG_FALL_MARGIN: fall_margin     <= pwdata[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (reg_idx)
      REG_PRESENT_MV:  prdata = PDATA_W'(present_mv);
      REG_EXTERNAL_MV: prdata = PDATA_W'(external_mv);
      REG_LOW_ENTER:   prdata = PDATA_W'(low_enter_level);
      REG_LOW_EXIT:    prdata = PDATA_W'(low_exit_level);
      REG_FALL_MARGIN: prdata = PDATA_W'(fall_margin);
      default:         prdata = '0;
    endcase
  end

  // voltage flags and low flag hysteresis
  always_comb begin
    present  = cur.millivolts > present_mv;
    external = cur.millivolts > external_mv;
    if (!low_flag && cur.level < low_enter_level) begin
      low_next = 1'b1;
    end else if (low_flag && cur.level > low_exit_level) begin
      low_next = 1'b0;
    end else begin
      low_next = low_flag;
    end
  end

  // reported level falls only past the margin, rises freely
  always_comb begin
    avg_margin = (LEVEL_W+1)'(avg.value) + (LEVEL_W+1)'(fall_margin);
    if (avg_margin < shown_level) begin
      shown_next = avg_margin;
    end else if ((LEVEL_W+1)'(avg.value) > shown_level) begin
      shown_next = (LEVEL_W+1)'(avg.value);
    end else begin
      shown_next = shown_level;
    end
  end

  // led priority
  always_comb begin
    if (cur.charging) begin
      led = LED_PULSE;
    end else if (cur.charged) begin
      led = LED_SOLID;
    end else if (external) begin
      led = LED_PULSE;
    end else if (low_next) begin
      led = LED_LOW;
    end else begin
      led = LED_ACTIVE;
    end
  end

  // item in work and per-sample state
  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      shown_level <= (LEVEL_W+1)'(UNSET_LEVEL);
      low_flag    <= 1'b0;
      started     <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
      end else if (take) begin
        busy <= 1'b0;
      end
      if (take) begin
        shown_level <= shown_next;
        low_flag    <= low_next;
        started     <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur <= sample;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (take) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      result.battery_present   <= present;
      result.external_power    <= external;
      result.power_off_request <= (present && cur.level == '0) || cur.docked;
      result.low_battery       <= low_next;
      result.reported_level    <= shown_next[LEVEL_W-1:0];
      result.power_source      <= cur.charging || cur.charged || external;
      result.led_pattern       <= led;
      result.first_sample      <= !started;
    end
  end

endmodule

### hw/rtl/blm_hist_mem.sv
// blm_hist_mem: history sample memory, one write and one registered read port
// depends on blm_pkg for the sample width
module blm_hist_mem import blm_pkg::*; #(
  parameter int DEPTH  = HISTORY_DEPTH_DEF,
  parameter int ADDR_W = 4
) (
  input  logic               clk,
  input  logic               wr_en,
  input  logic [ADDR_W-1:0]  wr_addr,
  input  logic [LEVEL_W-1:0] wr_data,
  input  logic               rd_en,
  input  logic [ADDR_W-1:0]  rd_addr,
  output logic [LEVEL_W-1:0] rd_data
);

  logic [LEVEL_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hw/rtl/blm_avg_div.sv
// blm_avg_div: divides the history sum by a fixed divisor
// shift for a power-of-two divisor, else one reciprocal multiply; uses blm_pkg
module blm_avg_div import blm_pkg::*; #(
  parameter int DIVISOR = HISTORY_DEPTH_DEF + 1,
  parameter int SUM_W   = 18
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [SUM_W-1:0]   dividend,
  output logic               done,
  output logic [LEVEL_W-1:0] quotient
);

  localparam bit IS_POW2 = (DIVISOR & (DIVISOR - 1)) == 0;
  localparam int SHIFT   = $clog2(DIVISOR);

  // quotient ready in the cycle after start
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= start;
    end
  end

  if (IS_POW2) begin : g_shift
    // plain shift
    always_ff @(posedge clk) begin
      if (start) begin
        quotient <= dividend[SHIFT +: LEVEL_W];
      end
    end
  end else begin : g_recip
    // ceil(2^(SUM_W+SHIFT) / DIVISOR) is exact for every SUM_W-bit sum
    localparam int RSH = SUM_W + SHIFT;
    localparam int RW  = SUM_W + 1;
    localparam int PW  = SUM_W + RW;
    localparam longint unsigned RECIP_FULL =
      ((64'd1 << RSH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [RW-1:0] RECIP = RW'(RECIP_FULL);

    logic [PW-1:0] prod;

    assign prod = PW'(dividend) * PW'(RECIP);

    always_ff @(posedge clk) begin
      if (start) begin
        quotient <= prod[RSH +: LEVEL_W];
      end
    end
  end

endmodule

### hw/rtl/blm_seq.sv
// blm_seq: history pass sequencer; reads every entry, sums, divides, writes the sample back
// depends on blm_pkg, blm_hist_mem and blm_avg_div
module blm_seq import blm_pkg::*; #(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [LEVEL_W-1:0] level,
  input  logic               take,
  output blm_avg_t           avg_out
);

  localparam int ADDR_W    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int SUM_W     = $clog2((HISTORY_DEPTH + 1) * (2 ** LEVEL_W));
  // reciprocal scale exact for every level and divisors up to 64
  localparam int REC_SHIFT = LEVEL_W + 6;
  localparam int REC_W     = REC_SHIFT + 1;
  localparam int PROD_W    = LEVEL_W + REC_W;
  localparam logic [ADDR_W-1:0] LAST = ADDR_W'(HISTORY_DEPTH - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DRAIN,
    S_DIV_GO,
    S_DIV_WAIT,
    S_DONE
  } state_t;

  state_t                   state;
  logic [ADDR_W-1:0]        cnt;
  logic [ADDR_W-1:0]        slot;
  logic [HISTORY_DEPTH-1:0] written;
  logic [LEVEL_W-1:0]       cur_level;
  logic [SUM_W-1:0]         acc;
  logic                     p1_valid;
  logic                     p1_written;
  logic [PROD_W-1:0]        p1_prod;
  logic [LEVEL_W-1:0]       term;
  logic [LEVEL_W-1:0]       avg;
  logic [LEVEL_W-1:0]       rd_data;
  logic                     div_done;
  logic [LEVEL_W-1:0]       div_quot;
  logic [REC_W-1:0]         recip_tab [HISTORY_DEPTH];

  // ceil(2^REC_SHIFT / (i+1)): level * entry >> REC_SHIFT is level / (i+1)
  for (genvar g = 0; g < HISTORY_DEPTH; g++) begin : g_recip
    localparam int unsigned Div = g + 1;
    localparam logic [REC_W-1:0] Recip = REC_W'(((1 << REC_SHIFT) + Div - 1) / Div);
    assign recip_tab[g] = Recip;
  end

  blm_hist_mem #(
    .DEPTH  (HISTORY_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (state == S_DIV_GO),
    .wr_addr (slot),
    .wr_data (cur_level),
    .rd_en   (state == S_READ),
    .rd_addr (cnt),
    .rd_data (rd_data)
  );

  blm_avg_div #(
    .DIVISOR (HISTORY_DEPTH + 1),
    .SUM_W   (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_DIV_GO),
    .dividend (acc),
    .done     (div_done),
    .quotient (div_quot)
  );

  // stored sample if written, else the scaled-down current level
  assign term = p1_written ? rd_data : p1_prod[REC_SHIFT +: LEVEL_W];

  // control: one entry read per cycle, write-back once all reads are done
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      slot     <= '0;
      written  <= '0;
      p1_valid <= 1'b0;
    end else begin
      p1_valid <= (state == S_READ);
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_READ;
            cnt   <= '0;
          end
        end
        S_READ: begin
          cnt <= (cnt == LAST) ? '0 : cnt + 1'b1;
          if (cnt == LAST) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          state <= S_DIV_GO;
        end
        S_DIV_GO: begin
          written[slot] <= 1'b1;
          slot          <= (slot == LAST) ? '0 : slot + 1'b1;
          state         <= S_DIV_WAIT;
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath: reciprocal product stage, then accumulate
  always_ff @(posedge clk) begin
    if (start && state == S_IDLE) begin
      cur_level <= level;
      acc       <= SUM_W'(level);
    end else if (p1_valid) begin
      acc <= acc + SUM_W'(term);
    end
    p1_written <= written[cnt];
    p1_prod    <= PROD_W'(cur_level) * PROD_W'(recip_tab[cnt]);
    if (state == S_DIV_WAIT && div_done) begin
      avg <= div_quot;
    end
  end

  assign avg_out.valid = (state == S_DONE);
  assign avg_out.value = avg;

endmodule

### hw/rtl/blm_checker.sv
// blm_checker: port-level checks of the battery level monitor, bound to the top level
// depends on blm_pkg and battery_level_monitor
module blm_checker import blm_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               sample_valid,
  input logic               sample_stall,
  input blm_sample_t        sample,
  input logic               result_valid,
  input logic               result_stall,
  input blm_result_t        result,
  input logic               psel,
  input logic               penable,
  input logic               pwrite,
  input logic [PADDR_W-1:0] paddr,
  input logic [PDATA_W-1:0] pwdata,
  input logic [PDATA_W-1:0] prdata,
  input logic               pready
);

  // a stalled result item holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("stalled result item changed");

  // one sample in work at a time
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> sample_stall)
    else $error("sample taken while another is in work");

  // external power always shows as a power source and a charge pattern
  a_external_led: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.external_power |->
      result.power_source &&
      (result.led_pattern == LED_PULSE || result.led_pattern == LED_SOLID))
    else $error("external power with wrong source or led");

  // low blink only with the low flag set and no power source
  a_low_led: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.led_pattern == LED_LOW |->
      result.low_battery && !result.power_source)
    else $error("low led without low flag");

endmodule

bind battery_level_monitor blm_checker u_blm_checker (.*);

### sim/battery_level_monitor_test.sv
// battery_level_monitor_test: self-checking bench for the battery level monitor
// drives samples and register writes, predicts every result item and compares field by field
// depends on blm_pkg and battery_level_monitor
module battery_level_monitor_test;
  import blm_pkg::*;

  localparam int CLK_PERIOD = 12;
  localparam int DEPTH = HISTORY_DEPTH_DEF;
  localparam int SETTLE_CYCLES = 48;
  localparam int ITEM_TARGET = 1550;
  localparam int HOLD_CYCLES = 300;
  localparam int TIMEOUT_CYCLES = 600000;
  localparam int LEVEL_TOP = 10000;
  localparam int MV_TOP = 8191;
  localparam int MARGIN_TOP = 1023;

  logic               clk;
  logic               rst;
  logic               sample_valid;
  logic               sample_stall;
  blm_sample_t        sample;
  logic               result_valid;
  logic               result_stall;
  blm_result_t        result;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // register copy kept by the predictor
  int unsigned cfg_present_mv;
  int unsigned cfg_external_mv;
  int unsigned cfg_low_enter;
  int unsigned cfg_low_exit;
  int unsigned cfg_fall_margin;

  // predictor state
  int unsigned hist_level [DEPTH];
  bit          hist_filled [DEPTH];
  int unsigned next_slot;
  int unsigned shown_level;
  bit          low_seen;
  bit          sample_seen;

  // expected result items, oldest first
  blm_result_t pending_status [$];

  int error_count;
  int items_sent;
  int results_checked;
  int settings_used;
  int walk_level;

  // idling control
  bit tx_idle;
  bit rx_idle;
  int rx_hold;
  int rx_wait_left;

  battery_level_monitor i_dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // work out the result of one sample and advance the predictor state
  function automatic blm_result_t predict_battery_status(blm_sample_t s);
    blm_result_t r;
    int unsigned sum;
    int unsigned avg;
    bit present;
    bit external;
    present = s.millivolts > cfg_present_mv;
    external = s.millivolts > cfg_external_mv;
    r.battery_present = present;
    r.external_power = external;
    r.power_off_request = (present && s.level == 0) || s.docked;
    r.first_sample = !sample_seen;
    sample_seen = 1'b1;

    // low flag with separate enter and exit levels
    if (!low_seen && s.level < cfg_low_enter) begin
      low_seen = 1'b1;
    end else if (low_seen && s.level > cfg_low_exit) begin
      low_seen = 1'b0;
    end
    r.low_battery = low_seen;

    // average, unwritten entries stand in as a fraction of the sample
    sum = s.level;
    for (int i = 0; i < DEPTH; i++) begin
      sum += hist_filled[i] ? hist_level[i] : s.level / int'(i + 1);
    end
    avg = sum / (DEPTH + 1);
    hist_level[next_slot] = s.level;
    hist_filled[next_slot] = 1'b1;
    next_slot = (next_slot + 1 >= DEPTH) ? 0 : next_slot + 1;

    // reported level rises freely, falls only past the margin
    if (avg + cfg_fall_margin < shown_level) begin
      shown_level = avg + cfg_fall_margin;
    end else if (avg > shown_level) begin
      shown_level = avg;
    end
    r.reported_level = LEVEL_W'(shown_level);
    r.power_source = s.charging || s.charged || external;

    // led priority
    if (s.charging) begin
      r.led_pattern = LED_PULSE;
    end else if (s.charged) begin
      r.led_pattern = LED_SOLID;
    end else if (external) begin
      r.led_pattern = LED_PULSE;
    end else if (low_seen) begin
      r.led_pattern = LED_LOW;
    end else begin
      r.led_pattern = LED_ACTIVE;
    end
    return r;
  endfunction

  function automatic blm_sample_t make_sample(int lvl, int mv, bit dock, bit chg, bit full);
    blm_sample_t s;
    s.level = LEVEL_W'(lvl);
    s.millivolts = MV_W'(mv);
    s.docked = dock;
    s.charging = chg;
    s.charged = full;
    return s;
  endfunction

  function automatic int near_value(int centre, int top);
    int v;
    v = centre + int'($urandom_range(0, 4)) - 2;
    if (v < 0) v = 0;
    if (v > top) v = top;
    return v;
  endfunction

  // random sample: mostly a drifting level with voltages near the thresholds
  function automatic blm_sample_t random_sample();
    int pick;
    int lvl;
    int mv;
    pick = $urandom_range(0, 99);
    if (pick < 2) begin
      lvl = $urandom_range(LEVEL_TOP + 1, (1 << LEVEL_W) - 1);
    end else if (pick < 6) begin
      lvl = 0;
    end else if (pick < 12) begin
      lvl = $urandom_range(0, LEVEL_TOP);
    end else if (pick < 22) begin
      lvl = near_value(pick < 17 ? cfg_low_enter : cfg_low_exit, LEVEL_TOP);
    end else begin
      walk_level += int'($urandom_range(0, 800)) - 420;
      if (walk_level < 0) walk_level = $urandom_range(0, 300);
      if (walk_level > LEVEL_TOP) walk_level = LEVEL_TOP - int'($urandom_range(0, 300));
      lvl = walk_level;
    end
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      mv = $urandom_range(0, MV_TOP);
    end else if (pick < 60) begin
      mv = near_value(cfg_present_mv, MV_TOP);
    end else if (pick < 90) begin
      mv = near_value(cfg_external_mv, MV_TOP);
    end else begin
      mv = (pick < 95) ? 0 : MV_TOP;
    end
    return make_sample(lvl, mv, $urandom_range(0, 9) == 0, $urandom_range(0, 3) == 0,
                       $urandom_range(0, 3) == 0);
  endfunction

  // offer one item; called and returns at a falling edge
  task automatic send_sample(blm_sample_t s);
    int gap;
    gap = tx_idle ? $urandom_range(0, 14) : 0;
    if (gap > 0) begin
      sample_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample = s;
    sample_valid = 1'b1;
    do @(posedge clk); while (sample_stall);
    pending_status.push_back(predict_battery_status(s));
    items_sent++;
    @(negedge clk);
  endtask

  // stop offering and wait until every expected item has come back
  task automatic wait_for_drain();
    sample_valid = 1'b0;
    while (pending_status.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // register write with readback of mapped registers, only while the block is idle
  task automatic write_register(logic [PADDR_W-3:0] index, logic [PDATA_W-1:0] value);
    logic [PDATA_W-1:0] stored;
    bit mapped;
    mapped = 1'b1;
    stored = '0;
    case (index)
      REG_PRESENT_MV: begin
        stored = value & ((1 << MV_W) - 1);
        cfg_present_mv = stored;
      end
      REG_EXTERNAL_MV: begin
        stored = value & ((1 << MV_W) - 1);
        cfg_external_mv = stored;
      end
      REG_LOW_ENTER: begin
        stored = value & ((1 << LEVEL_W) - 1);
        cfg_low_enter = stored;
      end
      REG_LOW_EXIT: begin
        stored = value & ((1 << LEVEL_W) - 1);
        cfg_low_exit = stored;
      end
      REG_FALL_MARGIN: begin
        stored = value & ((1 << MARGIN_W) - 1);
        cfg_fall_margin = stored;
      end
      default: mapped = 1'b0;
    endcase

    // setup then access
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {index, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    if (mapped) begin
      @(negedge clk);
      psel = 1'b1;
      @(negedge clk);
      penable = 1'b1;
      do @(posedge clk); while (!pready);
      if (prdata !== stored) begin
        $display("%0t: register %0d readback expected %0d got %0d", $time, index, stored,
                 prdata);
        error_count++;
      end
      @(negedge clk);
      psel = 1'b0;
      penable = 1'b0;
    end
  endtask

  task automatic set_thresholds(int pres, int ext, int enter, int leave, int margin,
                                bit junk_high);
    logic [PDATA_W-1:0] junk;
    junk = junk_high ? $urandom : '0;
    write_register(REG_PRESENT_MV, (junk << MV_W) | pres);
    write_register(REG_EXTERNAL_MV, (junk << MV_W) | ext);
    write_register(REG_LOW_ENTER, (junk << LEVEL_W) | enter);
    write_register(REG_LOW_EXIT, (junk << LEVEL_W) | leave);
    write_register(REG_FALL_MARGIN, (junk << MARGIN_W) | margin);
    settings_used++;
  endtask

  // per-field comparison
  task automatic compare_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // check each accepted result item against the oldest expectation
  initial begin
    blm_result_t exp_res;
    forever begin
      @(posedge clk);
      if (!rst && result_valid && !result_stall) begin
        if (pending_status.size() == 0) begin
          $display("%0t: unexpected result item, expected none got %h", $time, result);
          error_count++;
        end else begin
          exp_res = pending_status.pop_front();
          compare_field("battery_present", exp_res.battery_present, result.battery_present);
          compare_field("external_power", exp_res.external_power, result.external_power);
          compare_field("power_off_request", exp_res.power_off_request,
                        result.power_off_request);
          compare_field("low_battery", exp_res.low_battery, result.low_battery);
          compare_field("reported_level", exp_res.reported_level, result.reported_level);
          compare_field("power_source", exp_res.power_source, result.power_source);
          compare_field("led_pattern", exp_res.led_pattern, result.led_pattern);
          compare_field("first_sample", exp_res.first_sample, result.first_sample);
        end
        results_checked++;
        rx_wait_left = rx_idle ? $urandom_range(0, 14) : 0;
      end
    end
  end

  // receiver stall: long hold-off first, then the wait drawn per item
  initial begin
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        result_stall = 1'b1;
        rx_hold--;
      end else if (rx_wait_left > 0) begin
        result_stall = 1'b1;
        rx_wait_left--;
      end else begin
        result_stall = 1'b0;
      end
    end
  end

  // directed samples at default registers
  task automatic test_directed_cases();
    send_sample(make_sample(LEVEL_TOP, 3700, 0, 0, 0));
    send_sample(make_sample(0, 3000, 0, 0, 0));
    send_sample(make_sample(0, 1500, 0, 0, 0));
    send_sample(make_sample(1200, 1501, 0, 0, 0));
    send_sample(make_sample(1600, 3600, 0, 0, 0));
    send_sample(make_sample(5000, 4300, 1, 0, 0));
    send_sample(make_sample(5000, 4301, 0, 0, 0));
    send_sample(make_sample(5000, 3800, 0, 1, 0));
    send_sample(make_sample(5000, 3800, 0, 0, 1));
    send_sample(make_sample(5000, 5000, 0, 1, 1));
    send_sample(make_sample(900, MV_TOP, 0, 0, 1));
    send_sample(make_sample(900, 3500, 0, 0, 0));
    send_sample(make_sample((1 << LEVEL_W) - 1, 0, 0, 0, 0));
    send_sample(make_sample(8192, 3700, 0, 0, 0));
    send_sample(make_sample(LEVEL_TOP, 3700, 1, 1, 1));
    send_sample(make_sample(9950, 3700, 0, 0, 0));
    send_sample(make_sample(9900, 3700, 0, 0, 0));
    send_sample(make_sample(0, 3700, 0, 0, 0));
    send_sample(make_sample(0, 0, 1, 0, 0));
    send_sample(make_sample(2000, 1501, 0, 0, 0));
    send_sample(make_sample(1500, 3700, 0, 0, 0));
    send_sample(make_sample(1501, 3700, 0, 0, 0));
  endtask

  // several register settings, extremes among them, each with a random burst
  task automatic test_register_settings();
    for (int phase = 0; phase < 6; phase++) begin
      wait_for_drain();
      case (phase)
        0: set_thresholds(0, 0, 0, 0, 0, 1'b0);
        1: set_thresholds(MV_TOP, MV_TOP, LEVEL_TOP, LEVEL_TOP, MARGIN_TOP, 1'b0);
        2: begin
          // unmapped addresses must leave every register alone
          write_register((PADDR_W-2)'(NUM_REGS), $urandom);
          write_register((PADDR_W-2)'(NUM_REGS + 2), $urandom);
          set_thresholds($urandom_range(0, MV_TOP), $urandom_range(0, MV_TOP),
                         $urandom_range(0, LEVEL_TOP), $urandom_range(0, LEVEL_TOP),
                         $urandom_range(0, MARGIN_TOP), 1'b1);
        end
        3: set_thresholds(3300, 3500, 4000, 3000, 0, 1'b0);
        4: set_thresholds($urandom_range(0, MV_TOP), $urandom_range(0, MV_TOP),
                          $urandom_range(0, 5000), $urandom_range(5000, LEVEL_TOP),
                          $urandom_range(0, MARGIN_TOP), 1'b1);
        default: set_thresholds(PRESENT_MV_RST, EXTERNAL_MV_RST, LOW_ENTER_RST,
                                LOW_EXIT_RST, FALL_MARGIN_RST, 1'b0);
      endcase
      tx_idle = phase[0];
      rx_idle = phase[1];
      repeat (100) send_sample(random_sample());
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // receiver holds off while the sender keeps offering, then the sender pauses
  task automatic test_output_backpressure();
    wait_for_drain();
    @(posedge clk);
    rx_hold = HOLD_CYCLES;
    @(negedge clk);
    tx_idle = 1'b0;
    repeat (12) send_sample(random_sample());
    wait_for_drain();
    tx_idle = 1'b1;
  endtask

  // long random stream in stretches with and without idling
  task automatic test_random_stream();
    int chunk;
    while (items_sent < ITEM_TARGET) begin
      chunk = $urandom_range(0, 3);
      tx_idle = chunk[0];
      rx_idle = chunk[1];
      repeat (50) send_sample(random_sample());
    end
  endtask

  // stimulus sequence
  initial begin
    rst = 1'b1;
    sample_valid = 1'b0;
    sample = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    error_count = 0;
    items_sent = 0;
    results_checked = 0;
    settings_used = 1;
    walk_level = 5000;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    rx_hold = 0;
    rx_wait_left = 0;
    cfg_present_mv = PRESENT_MV_RST;
    cfg_external_mv = EXTERNAL_MV_RST;
    cfg_low_enter = LOW_ENTER_RST;
    cfg_low_exit = LOW_EXIT_RST;
    cfg_fall_margin = FALL_MARGIN_RST;
    for (int i = 0; i < DEPTH; i++) begin
      hist_level[i] = 0;
      hist_filled[i] = 1'b0;
    end
    next_slot = 0;
    shown_level = UNSET_LEVEL;
    low_seen = 1'b0;
    sample_seen = 1'b0;
    repeat (7) @(negedge clk);
    rst = 1'b0;
    repeat (SETTLE_CYCLES) @(negedge clk);

    test_directed_cases();
    test_register_settings();
    test_output_backpressure();
    test_random_stream();
    wait_for_drain();

    $display("run covered %0d samples under %0d register settings, %0d results compared",
             items_sent, settings_used, results_checked);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("timeout with %0d result items outstanding", pending_status.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule

### battery_level_monitor.f
hw/rtl/blm_pkg.sv
hw/rtl/blm_hist_mem.sv
hw/rtl/blm_avg_div.sv
hw/rtl/blm_seq.sv
hw/rtl/battery_level_monitor.sv
hw/rtl/blm_checker.sv
sim/battery_level_monitor_test.sv
